[rtl/fcw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcw_pkg: shared definitions of the cluster chain walker
// Table geometry, field widths, codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package fcw_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W     = 28;
    localparam int LIMIT_W     = 7;
    localparam int TOTAL_W     = 6;
    localparam int COUNT_W     = 7;

    // cluster value classes
    localparam logic [31:0] END_OF_CHAIN = 32'h0FFF_FFF8;
    localparam logic [31:0] FIRST_DATA   = 32'd2;
    localparam logic [TOTAL_W-1:0] MAX_CLUSTERS = 6'd62;

    // status codes of the final item
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_RANGE   = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    // item opcodes
    localparam logic OP_WALK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // configuration register indexes
    localparam logic CFG_TOTAL_CLUSTERS = 1'b0;
    localparam logic CFG_TABLE_ENTRIES  = 1'b1;

    // effective configuration seen by the sequencer
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [LIMIT_W-1:0] limit;
    } fcw_cfg_t;

    // table write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [ENTRY_W-1:0] data;
    } fcw_wr_t;

    // one result item
    typedef struct packed {
        logic        cluster_valid;
        logic [31:0] cluster_number;
        logic [1:0]  status;
        logic [31:0] error_detail;
        logic        last;
    } fcw_item_t;

endpackage
`default_nettype wire

[rtl/fcw_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcw_store: allocation table storage
// One write and one registered read per cycle; per-entry valid bits make an
// entry that was never written since reset read as zero (free).
// ----------------------------------------------------------------------------
module fcw_store (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire fcw_pkg::fcw_wr_t             wr,
    input  wire logic                         rd_en,
    input  wire logic [fcw_pkg::ADDR_W-1:0]   rd_addr,
    output logic [fcw_pkg::ENTRY_W-1:0]       rd_data
);

    logic [fcw_pkg::ENTRY_W-1:0]     mem [fcw_pkg::TABLE_DEPTH];
    logic [fcw_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [fcw_pkg::ENTRY_W-1:0]     rd_data_reg;
    logic                            rd_valid_reg;

    // entry storage and registered read
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

[rtl/fcw_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcw_seq: chain walk sequencer
// Steps one cluster at a time through the table with a shared classify and
// compare unit, and holds the result item register.
// ----------------------------------------------------------------------------
module fcw_seq (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire fcw_pkg::fcw_cfg_t            cfg,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic                         opcode,
    input  wire logic [31:0]                  start_cluster,
    input  wire logic [5:0]                   entry_index,
    input  wire logic [31:0]                  entry_value,
    output fcw_pkg::fcw_wr_t                  wr,
    output logic                              rd_en,
    output logic [fcw_pkg::ADDR_W-1:0]        rd_addr,
    input  wire logic [fcw_pkg::ENTRY_W-1:0]  rd_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output fcw_pkg::fcw_item_t                m_item
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT,
        ST_RANGE
    } state_t;

    state_t                        state_reg;
    logic [31:0]                   cur_reg;
    logic [fcw_pkg::COUNT_W-1:0]   count_reg;
    logic                          m_valid_reg;
    fcw_pkg::fcw_item_t            m_item_reg;
    fcw_pkg::fcw_item_t            m_item_next;

    logic out_free;
    logic accept;
    logic load_item;
    logic is_data;
    logic is_end;
    logic count_full;
    logic over_limit;

    // shared classify and compare unit on the current cluster value
    always_comb begin
        is_data    = (cur_reg >= fcw_pkg::FIRST_DATA) &&
                     (cur_reg < (32'(cfg.total) + fcw_pkg::FIRST_DATA));
        is_end     = (cur_reg >= fcw_pkg::END_OF_CHAIN);
        count_full = (count_reg >= {1'b0, cfg.total});
        over_limit = (cur_reg >= 32'(cfg.limit));
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // table write on an accepted write item
    always_comb begin
        wr.en   = accept && (opcode == fcw_pkg::OP_WRITE) &&
                  (32'(entry_index) < 32'(fcw_pkg::TABLE_DEPTH));
        wr.addr = entry_index[fcw_pkg::ADDR_W-1:0];
        wr.data = entry_value[fcw_pkg::ENTRY_W-1:0];
    end

    // table read of the cluster just emitted
    assign rd_en   = (state_reg == ST_CHECK) && out_free && is_data &&
                     !count_full && !over_limit;
    assign rd_addr = cur_reg[fcw_pkg::ADDR_W-1:0];

    // next result item and when it enters the output register
    always_comb begin
        load_item   = 1'b0;
        m_item_next = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (opcode == fcw_pkg::OP_WRITE)) begin
                    load_item        = 1'b1;
                    m_item_next.last = 1'b1;
                end
            end
            ST_CHECK: begin
                if (out_free) begin
                    load_item = 1'b1;
                    if (!is_data) begin
                        m_item_next.last = 1'b1;
                        if (!is_end) begin
                            m_item_next.status       = fcw_pkg::STATUS_INVALID;
                            m_item_next.error_detail = cur_reg;
                        end
                    end else if (count_full) begin
                        m_item_next.last         = 1'b1;
                        m_item_next.status       = fcw_pkg::STATUS_RANGE;
                        m_item_next.error_detail = 32'(count_reg);
                    end else begin
                        m_item_next.cluster_valid  = 1'b1;
                        m_item_next.cluster_number = cur_reg;
                    end
                end
            end
            ST_RANGE: begin
                if (out_free) begin
                    load_item                = 1'b1;
                    m_item_next.last         = 1'b1;
                    m_item_next.status       = fcw_pkg::STATUS_RANGE;
                    m_item_next.error_detail = cur_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer and result item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cur_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_item_reg  <= '0;
        end else begin
            if (load_item) begin
                m_valid_reg <= 1'b1;
                m_item_reg  <= m_item_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && (opcode == fcw_pkg::OP_WALK)) begin
                        cur_reg   <= start_cluster;
                        count_reg <= '0;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (out_free) begin
                        if (!is_data || count_full) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            count_reg <= count_reg + fcw_pkg::COUNT_W'(1);
                            state_reg <= over_limit ? ST_RANGE : ST_WAIT;
                        end
                    end
                end
                ST_WAIT: begin
                    cur_reg   <= 32'(rd_data);
                    state_reg <= ST_CHECK;
                end
                ST_RANGE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // a cluster item never closes a response
    a_cluster_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.cluster_valid |-> !m_item_reg.last)
        else $error("cluster item marked last");

    // a table read is always followed by the load cycle
    a_read_then_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> (state_reg == ST_WAIT))
        else $error("table read without load cycle");

    // reads stay inside the table in use
    a_read_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (cur_reg < 32'(cfg.limit)))
        else $error("table read beyond limit");

    // walk count stays within the cluster guard
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= {1'b0, fcw_pkg::MAX_CLUSTERS})
        else $error("walk count beyond guard");

    // a write item is answered in the next cycle with an acknowledge item
    a_write_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (opcode == fcw_pkg::OP_WRITE) |=>
            m_valid_reg && m_item_reg.last && !m_item_reg.cluster_valid)
        else $error("write item not acknowledged");

endmodule
`default_nettype wire

[rtl/fat_cluster_chain_walker_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fat_cluster_chain_walker_top: FAT32 cluster chain walker
// Allocation table with write and chain walk items on stream channels.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one item at a time; s_tuser is the opcode (0 walk,
//   1 write). A write item stores the low 28 bits of entry_value and is
//   answered by one acknowledge item in the cycle after acceptance.
//   A walk item yields one m_ item per chain cluster (m_tuser high) and
//   then one status item with m_tlast high.
//   Timing: each cluster passes through ST_CHECK (classify and emit with
//   the table read) and then ST_WAIT (load), paced by the loop through
//   the single registered table read port. s_tready stays low until the
//   final item of a walk is being taken from the output register.
//   When m_tready is low the output register holds its item and the walk
//   pauses; nothing is dropped.
//   Reset: all table entries read as free (zero) at once through valid
//   bits, total_clusters = 0, table_entries = 64. No clearing pass.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index (0 total_clusters,
//   1 table_entries); the user must do so only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module fat_cluster_chain_walker_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: start_cluster[31:0], entry_index[37:32], entry_value[69:38], zero pad
    input  wire logic [71:0] s_tdata,
    // s_tuser: opcode
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: cluster_number[31:0], status[33:32], error_detail[65:34], zero pad
    output logic [71:0]      m_tdata,
    // m_tuser: cluster_valid
    output logic             m_tuser,
    output logic             m_tlast
);

    logic [fcw_pkg::TOTAL_W-1:0] total_clusters_reg;
    logic [fcw_pkg::LIMIT_W-1:0] table_entries_reg;
    fcw_pkg::fcw_cfg_t           cfg;
    fcw_pkg::fcw_wr_t            wr;
    logic                        rd_en;
    logic [fcw_pkg::ADDR_W-1:0]  rd_addr;
    logic [fcw_pkg::ENTRY_W-1:0] rd_data;
    fcw_pkg::fcw_item_t          m_item;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_clusters_reg <= '0;
            table_entries_reg  <= fcw_pkg::LIMIT_W'(fcw_pkg::TABLE_DEPTH);
        end else if (cfg_we) begin
            case (cfg_index)
                fcw_pkg::CFG_TOTAL_CLUSTERS: total_clusters_reg <= cfg_wdata[5:0];
                fcw_pkg::CFG_TABLE_ENTRIES:  table_entries_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // clamp to the guard count and the physical table size
    always_comb begin
        cfg.total = (total_clusters_reg > fcw_pkg::MAX_CLUSTERS) ?
                    fcw_pkg::MAX_CLUSTERS : total_clusters_reg;
        cfg.limit = (table_entries_reg > fcw_pkg::LIMIT_W'(fcw_pkg::TABLE_DEPTH)) ?
                    fcw_pkg::LIMIT_W'(fcw_pkg::TABLE_DEPTH) : table_entries_reg;
    end

    fcw_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fcw_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .opcode        (s_tuser),
        .start_cluster (s_tdata[31:0]),
        .entry_index   (s_tdata[37:32]),
        .entry_value   (s_tdata[69:38]),
        .wr            (wr),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_item        (m_item)
    );

    // result item packing
    assign m_tdata = {6'd0, m_item.error_detail, m_item.status, m_item.cluster_number};
    assign m_tuser = m_item.cluster_valid;
    assign m_tlast = m_item.last;

endmodule
`default_nettype wire

[tb/fat_chain_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_monitor: cluster chain walker scoreboard
// Watches the register port and both stream channels, keeps its own copy of
// the allocation table, traces every walk to the items the block should send
// and compares each accepted result item field by field.
// ----------------------------------------------------------------------------
module fat_chain_monitor
    import fcw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // s_tdata: start_cluster[31:0], entry_index[37:32], entry_value[69:38], zero pad
    input  logic [71:0] s_tdata,
    // s_tuser: opcode
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: cluster_number[31:0], status[33:32], error_detail[65:34], zero pad
    input  logic [71:0] m_tdata,
    // m_tuser: cluster_valid
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          outstanding,
    output int          mismatches
);

    localparam int PRINT_CAP = 50;

    logic [ENTRY_W-1:0] fat_copy [TABLE_DEPTH];
    logic [TOTAL_W-1:0] total_reg;
    logic [LIMIT_W-1:0] entries_reg;
    fcw_item_t          chain_items [$];

    // one line per mismatch, counted even once printing stops
    task automatic report(input string field, input logic [31:0] got_v,
                          input logic [31:0] want_v);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("%0t mismatch on %s: got %h, want %h", $time, field, got_v, want_v);
        end
    endtask

    task automatic add_item(input logic valid, input logic [31:0] number,
                            input logic [1:0] st, input logic [31:0] detail,
                            input logic fin);
        fcw_item_t it;
        it.cluster_valid  = valid;
        it.cluster_number = number;
        it.status         = st;
        it.error_detail   = detail;
        it.last           = fin;
        chain_items.insert(chain_items.size(), it);
    endtask

    // follow the chain from the first cluster and queue the items it yields
    task automatic trace_chain(input logic [31:0] first);
        logic [31:0] cur;
        int unsigned span;
        int unsigned lim;
        int unsigned count;
        span  = (total_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : total_reg;
        lim   = (entries_reg > TABLE_DEPTH) ? TABLE_DEPTH : entries_reg;
        cur   = first;
        count = 0;
        while (cur >= FIRST_DATA && cur < FIRST_DATA + span) begin
            // loop guard: count already at the cluster total
            if (count >= span) begin
                add_item(1'b0, '0, STATUS_RANGE, 32'(count), 1'b1);
                return;
            end
            add_item(1'b1, cur, STATUS_OK, '0, 1'b0);
            count++;
            // table read past the entries in use
            if (cur >= lim) begin
                add_item(1'b0, '0, STATUS_RANGE, cur, 1'b1);
                return;
            end
            cur = 32'(fat_copy[cur[ADDR_W-1:0]]);
        end
        // chain ended on a non-data value
        if (cur < END_OF_CHAIN) begin
            add_item(1'b0, '0, STATUS_INVALID, cur, 1'b1);
        end else begin
            add_item(1'b0, '0, STATUS_OK, '0, 1'b1);
        end
    endtask

    task automatic check_item(input fcw_item_t got);
        fcw_item_t want;
        if (chain_items.size() == 0) begin
            report("item with none outstanding", got.cluster_number, '0);
            return;
        end
        want = chain_items.pop_front();
        if (got.cluster_valid !== want.cluster_valid) begin
            report("cluster_valid", 32'(got.cluster_valid), 32'(want.cluster_valid));
        end
        if (got.cluster_number !== want.cluster_number) begin
            report("cluster_number", got.cluster_number, want.cluster_number);
        end
        if (got.status !== want.status) begin
            report("status", 32'(got.status), 32'(want.status));
        end
        if (got.error_detail !== want.error_detail) begin
            report("error_detail", got.error_detail, want.error_detail);
        end
        if (got.last !== want.last) begin
            report("last", 32'(got.last), 32'(want.last));
        end
    endtask

    always @(posedge aclk) begin : watch
        fcw_item_t got;
        if (!aresetn) begin
            foreach (fat_copy[i]) fat_copy[i] = '0;
            total_reg   = '0;
            entries_reg = LIMIT_W'(TABLE_DEPTH);
            chain_items.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                if (cfg_index == CFG_TOTAL_CLUSTERS) begin
                    total_reg = cfg_wdata[TOTAL_W-1:0];
                end else begin
                    entries_reg = cfg_wdata[LIMIT_W-1:0];
                end
            end
            // accepted input item
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_WRITE) begin
                    if (s_tdata[32 +: ADDR_W] < TABLE_DEPTH) begin
                        fat_copy[s_tdata[32 +: ADDR_W]] = s_tdata[38 +: ENTRY_W];
                    end
                    add_item(1'b0, '0, STATUS_OK, '0, 1'b1);
                end else begin
                    trace_chain(s_tdata[31:0]);
                end
            end
            // accepted result item
            if (m_tvalid && m_tready) begin
                got.cluster_valid  = m_tuser;
                got.cluster_number = m_tdata[31:0];
                got.status         = m_tdata[33:32];
                got.error_detail   = m_tdata[65:34];
                got.last           = m_tlast;
                check_item(got);
            end
        end
        outstanding <= chain_items.size();
    end

endmodule

[tb/fat_cluster_chain_walker_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_chain_walker_top_tb: cluster chain walker testbench
// Directed table writes and walks over the register extremes, then random
// chain building and walking under changing idle and stall patterns, with a
// long receiver hold-off; results are checked by the chain monitor.
// ----------------------------------------------------------------------------
module fat_cluster_chain_walker_top_tb;
    import fcw_pkg::*;

    localparam int      RESET_CYCLES  = 8;
    localparam int      HOLD_CYCLES   = 400;
    localparam int      RANDOM_PHASES = 8;
    localparam int      PHASE_ITEMS   = 32;
    localparam longint  LIMIT_NS      = 64'd20_000_000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic        cfg_index   = CFG_TOTAL_CLUSTERS;
    logic [6:0]  cfg_wdata   = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    // s_tdata: start_cluster[31:0], entry_index[37:32], entry_value[69:38], zero pad
    logic [71:0] s_tdata     = '0;
    // s_tuser: opcode
    logic        s_tuser     = OP_WALK;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    // m_tdata: cluster_number[31:0], status[33:32], error_detail[65:34], zero pad
    logic [71:0] m_tdata;
    // m_tuser: cluster_valid
    logic        m_tuser;
    logic        m_tlast;

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cur_total     = 0;
    int outstanding;
    int mismatches;

    fat_cluster_chain_walker_top u_top (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );

    fat_chain_monitor u_monitor (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .outstanding, .mismatches
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_tready    <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                tx_idle_pct = 0;
                rx_stall_pct <= 0;
            end
            IDLE_SENDER: begin
                tx_idle_pct = 58;
                rx_stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                tx_idle_pct = 0;
                rx_stall_pct <= 58;
            end
            default: begin
                tx_idle_pct = 12;
                rx_stall_pct <= 12;
            end
        endcase
    endtask

    // offer one item and hold it until accepted; valid stays high afterwards
    task automatic send_item(input logic op, input logic [31:0] start,
                             input logic [5:0] idx, input logic [31:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, val, idx, start};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic walk(input logic [31:0] start);
        send_item(OP_WALK, start, 6'($urandom), $urandom);
    endtask

    task automatic write_entry(input logic [5:0] idx, input logic [31:0] val);
        send_item(OP_WRITE, $urandom, idx, val);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_config(input logic [5:0] total, input logic [6:0] entries);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TOTAL_CLUSTERS;
        cfg_wdata <= {1'b0, total};
        @(posedge aclk);
        cfg_index <= CFG_TABLE_ENTRIES;
        cfg_wdata <= entries;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_total = (total > MAX_CLUSTERS) ? MAX_CLUSTERS : total;
    endtask

    // mostly chain links and walks over the data clusters, some noise
    task automatic random_item();
        int unsigned span;
        int unsigned pick;
        logic [31:0] link;
        logic [31:0] val;
        span = (cur_total == 0) ? 1 : cur_total;
        pick = $urandom_range(99);
        link = FIRST_DATA + $urandom_range(span - 1);
        if (pick < 40) begin
            // link a cluster onward, close the chain or break it
            case ($urandom_range(9))
                0, 1: val = {4'($urandom), 28'hFFFFFF8 | 28'($urandom_range(7))};
                2: val = {4'($urandom), ($urandom_range(1) ? 28'hFFFFFF7 : 28'($urandom_range(1)))};
                3: val = $urandom;
                default: val = {4'($urandom), 28'(FIRST_DATA + $urandom_range(span - 1))};
            endcase
            write_entry(6'(link), val);
        end else if (pick < 88) begin
            walk(link);
        end else if (pick < 94) begin
            write_entry(6'($urandom), $urandom);
        end else begin
            walk($urandom_range(1) ? $urandom : 32'($urandom_range(70)));
        end
    endtask

    initial begin : stimulus
        logic [5:0] total;
        logic [6:0] entries;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        set_idle(IDLE_NONE);

        // reset configuration: no data clusters at all
        walk(32'd0);
        walk(32'd1);
        walk(FIRST_DATA);
        walk(32'hFFFF_FFFF);
        walk(END_OF_CHAIN);
        walk(END_OF_CHAIN - 1);
        write_entry(6'd63, 32'hFFFF_FFFF);
        write_entry(6'd0, 32'd0);

        // full size: short chain, loop to the cluster limit, chain ends
        set_config(6'd62, 7'd64);
        write_entry(6'd2, 32'hF000_0003);
        write_entry(6'd3, 32'd4);
        write_entry(6'd4, END_OF_CHAIN);
        walk(32'd2);
        write_entry(6'd5, 32'd5);
        walk(32'd5);
        walk(32'd63);
        write_entry(6'd6, 32'h0FFF_FFF7);
        walk(32'd6);
        write_entry(6'd7, 32'd1);
        walk(32'd7);
        walk(32'd8);

        // small table: chain leaves the entries in use
        set_config(6'd62, 7'd10);
        write_entry(6'd2, 32'd12);
        walk(32'd2);

        // oversized registers are clamped
        set_config(6'd63, 7'd127);
        walk(32'd63);
        walk(32'd64);

        // empty table
        set_config(6'd5, 7'd0);
        walk(32'd2);

        // random phases
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(4))
                0: total = 6'd0;
                1: total = 6'd62;
                2: total = 6'd63;
                default: total = 6'($urandom_range(12, 1));
            endcase
            case ($urandom_range(4))
                0: entries = 7'd0;
                1: entries = 7'd64;
                2: entries = 7'($urandom_range(127, 65));
                default: entries = 7'($urandom_range(20, 2));
            endcase
            set_config(total, entries);
            set_idle(idle_mode_t'(p % 4));
            // long receiver hold-off while items keep coming
            if (p == 0 || p == 4) begin
                hold_requests <= hold_requests + 1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                random_item();
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/fcw_pkg.sv
rtl/fcw_store.sv
rtl/fcw_seq.sv
rtl/fat_cluster_chain_walker_top.sv
tb/fat_chain_monitor.sv
tb/fat_cluster_chain_walker_top_tb.sv
